FILE: rtl/hsv_to_rgb_pwm_compare_assert.svh
// assertion macros shared by the hsv to rgb pwm compare rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef HSV_TO_RGB_PWM_COMPARE_ASSERT_SVH
`define HSV_TO_RGB_PWM_COMPARE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HRPC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HRPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hrpc_pkg.sv
// constants and register codes for the hsv to rgb pwm compare block
// depends on nothing; imported by hsv_to_rgb_pwm_compare
package hrpc_pkg;

    // field widths
    localparam int HUE_W   = 16;
    localparam int Q12_W   = 13;
    localparam int CMP_W   = 16;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 48;

    // hue period and sector width in 1/64 degree units
    localparam logic [15:0] HUE_PERIOD   = 16'd23040;
    localparam logic [15:0] HUE_PERIOD_2 = 16'd46080;
    localparam logic [11:0] SECTOR_W     = 12'd3840;

    // 1.0 in q1.12
    localparam logic [12:0] ONE_Q12 = 13'd4096;

    // channel weight when a channel carries the full chroma: 4096 * 3840
    localparam logic [23:0] W_FULL = 24'd15728640;

    // the 3840 divisor is 256 * 15; the 256 folds into the 2^36 shift
    localparam int          POST_SHIFT  = 44;
    // ceil(2^28 / 15), exact floor for any quotient input below 2^20
    localparam logic [24:0] RECIP_15    = 25'd17895698;
    localparam int          RECIP_SHIFT = 28;
    // largest value that reaches the divide-by-15 stage: 65535 * 15
    localparam logic [19:0] Y_MAX       = 20'd983025;

    // reset full-scale counts
    localparam logic [15:0] RED_MAX_RST   = 16'd200;
    localparam logic [15:0] GREEN_MAX_RST = 16'd70;
    localparam logic [15:0] BLUE_MAX_RST  = 16'd70;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RED_MAX   = 2'd0,
        REG_GREEN_MAX = 2'd1,
        REG_BLUE_MAX  = 2'd2
    } cfg_reg_t;

endpackage

FILE: rtl/hsv_to_rgb_pwm_compare.sv
// Converts one hue/saturation/value beat per clock, while the output is not
// stalled, into three PWM compare counts. Six registered stages: hue reduction
// and sector split, value squaring with the chroma weights, per-channel weight
// select, weight times squared value, times the full-scale count, then an exact
// divide by 15 through a reciprocal multiply. Without stalls, a new beat may
// enter every cycle and throughput is one beat per cycle, set by the pipeline
// of multipliers (the 49 by 16 full-scale product is the deepest stage).
// Stalls on the output side back up stage by stage, so empty stages keep
// accepting. Results are exact floors, no intermediate rounding. Full-scale
// registers are written through cfg_we/cfg_addr/cfg_wdata by the user only
// while the block is idle, unenforced by the block; writes to index 3 are ignored.
// depends on hrpc_pkg and hsv_to_rgb_pwm_compare_assert.svh
`include "hsv_to_rgb_pwm_compare_assert.svh"

module hsv_to_rgb_pwm_compare
    import hrpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // hue[15:0], saturation[28:16], brightness[41:29]
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // red_compare[15:0], green_compare[31:16],
                                         // blue_compare[47:32]
    // configuration write port
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [CMP_W-1:0]  cfg_wdata
);

    // full-scale registers
    logic [CMP_W-1:0] red_max_reg, green_max_reg, blue_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_max_reg   <= RED_MAX_RST;
            green_max_reg <= GREEN_MAX_RST;
            blue_max_reg  <= BLUE_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RED_MAX:   red_max_reg   <= cfg_wdata;
                REG_GREEN_MAX: green_max_reg <= cfg_wdata;
                REG_BLUE_MAX:  blue_max_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage load enables
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !vld6_reg || m_tready;
    assign rdy5     = !vld5_reg || rdy6;
    assign rdy4     = !vld4_reg || rdy5;
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = vld6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= s_tvalid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
            if (rdy5) vld5_reg <= vld4_reg;
            if (rdy6) vld6_reg <= vld5_reg;
        end
    end

    // stage 1: clamp, hue modulo 360 degrees, sector and offset in sector
    logic [HUE_W-1:0] hue_in;
    logic [Q12_W-1:0] sat_in, bri_in;
    logic [14:0]      h_mod;
    logic [2:0]       sector_next;
    logic [11:0]      frac_next;
    logic [Q12_W-1:0] sat_next, bri_next;

    assign hue_in = s_tdata[15:0];
    assign sat_in = s_tdata[28:16];
    assign bri_in = s_tdata[41:29];

    always_comb begin
        logic [15:0] h_full;
        logic [15:0] h_off;
        if (hue_in >= HUE_PERIOD_2)    h_full = hue_in - HUE_PERIOD_2;
        else if (hue_in >= HUE_PERIOD) h_full = hue_in - HUE_PERIOD;
        else                           h_full = hue_in;
        h_mod = h_full[14:0];

        if (h_full >= 16'd19200) begin
            sector_next = 3'd5;
            h_off       = h_full - 16'd19200;
        end else if (h_full >= 16'd15360) begin
            sector_next = 3'd4;
            h_off       = h_full - 16'd15360;
        end else if (h_full >= 16'd11520) begin
            sector_next = 3'd3;
            h_off       = h_full - 16'd11520;
        end else if (h_full >= 16'd7680) begin
            sector_next = 3'd2;
            h_off       = h_full - 16'd7680;
        end else if (h_full >= {4'd0, SECTOR_W}) begin
            sector_next = 3'd1;
            h_off       = h_full - {4'd0, SECTOR_W};
        end else begin
            sector_next = 3'd0;
            h_off       = h_full;
        end
        frac_next = h_off[11:0];

        sat_next = (sat_in > ONE_Q12) ? ONE_Q12 : sat_in;
        bri_next = (bri_in > ONE_Q12) ? ONE_Q12 : bri_in;
    end

    logic [2:0]       sector1_reg;
    logic [11:0]      frac1_reg;
    logic [14:0]      hmod1_reg;
    logic [Q12_W-1:0] sat1_reg, bri1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            sector1_reg <= sector_next;
            frac1_reg   <= frac_next;
            hmod1_reg   <= h_mod;
            sat1_reg    <= sat_next;
            bri1_reg    <= bri_next;
        end
    end

    // stage 2: squared value, chroma times hue ramp, offset weight
    logic [25:0] v2_prod;
    logic [11:0] tx;
    logic [24:0] sx_prod;
    logic [12:0] ns;
    logic [24:0] m_prod;
    logic [24:0] v2_next;
    logic [23:0] sx_next, m3840_next;

    assign v2_prod    = bri1_reg * bri1_reg;
    assign v2_next    = v2_prod[24:0];
    assign tx         = sector1_reg[0] ? (SECTOR_W - frac1_reg) : frac1_reg;
    assign sx_prod    = sat1_reg * tx;
    assign sx_next    = sx_prod[23:0];
    assign ns         = ONE_Q12 - sat1_reg;
    assign m_prod     = {ns, 12'd0} - {4'd0, ns, 8'd0};
    assign m3840_next = m_prod[23:0];

    logic [24:0] v2_2_reg;
    logic [23:0] sx2_reg, m3840_2_reg;
    logic [2:0]  sector2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            v2_2_reg    <= v2_next;
            sx2_reg     <= sx_next;
            m3840_2_reg <= m3840_next;
            sector2_reg <= sector1_reg;
        end
    end

    // stage 3: per-channel weight, full chroma, ramp or offset only
    logic [23:0] wx;
    logic [23:0] wr_next, wg_next, wb_next;

    assign wx = sx2_reg + m3840_2_reg;

    always_comb begin
        wr_next = m3840_2_reg;
        wg_next = m3840_2_reg;
        wb_next = m3840_2_reg;
        case (sector2_reg)
            3'd0: begin wr_next = W_FULL; wg_next = wx;     end
            3'd1: begin wr_next = wx;     wg_next = W_FULL; end
            3'd2: begin wg_next = W_FULL; wb_next = wx;     end
            3'd3: begin wg_next = wx;     wb_next = W_FULL; end
            3'd4: begin wr_next = wx;     wb_next = W_FULL; end
            default: begin wr_next = W_FULL; wb_next = wx;  end
        endcase
    end

    logic [24:0] v2_3_reg;
    logic [23:0] wr3_reg, wg3_reg, wb3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            v2_3_reg <= v2_2_reg;
            wr3_reg  <= wr_next;
            wg3_reg  <= wg_next;
            wb3_reg  <= wb_next;
        end
    end

    // stage 4: weight times squared value
    logic [48:0] qr_reg, qg_reg, qb_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            qr_reg <= v2_3_reg * wr3_reg;
            qg_reg <= v2_3_reg * wg3_reg;
            qb_reg <= v2_3_reg * wb3_reg;
        end
    end

    // stage 5: times full-scale count, drop 2^36 and the 256 part of 3840
    logic [64:0] pr, pg, pb;

    assign pr = qr_reg * red_max_reg;
    assign pg = qg_reg * green_max_reg;
    assign pb = qb_reg * blue_max_reg;

    logic [19:0] yr_reg, yg_reg, yb_reg;

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            yr_reg <= pr[63:POST_SHIFT];
            yg_reg <= pg[63:POST_SHIFT];
            yb_reg <= pb[63:POST_SHIFT];
        end
    end

    // stage 6: exact divide by 15 through reciprocal multiply
    logic [44:0] zr, zg, zb;

    assign zr = yr_reg * RECIP_15;
    assign zg = yg_reg * RECIP_15;
    assign zb = yb_reg * RECIP_15;

    logic [CMP_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            red_reg   <= zr[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
            green_reg <= zg[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
            blue_reg  <= zb[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
        end
    end

    assign m_tdata = {blue_reg, green_reg, red_reg};

    // checks on internal stage contents
    `HRPC_ASSERT_NOW(a_sector_range, aclk, aresetn, vld1_reg,
        (frac1_reg < SECTOR_W) && (sector1_reg <= 3'd5) && (hmod1_reg < 15'd23040),
        "hue reduction out of range")
    `HRPC_ASSERT_NOW(a_weight_range, aclk, aresetn, vld3_reg,
        (wr3_reg <= W_FULL) && (wg3_reg <= W_FULL) && (wb3_reg <= W_FULL),
        "channel weight exceeds full chroma")
    `HRPC_ASSERT_NOW(a_quot_range, aclk, aresetn, vld5_reg,
        (yr_reg <= Y_MAX) && (yg_reg <= Y_MAX) && (yb_reg <= Y_MAX),
        "divide stage input too large")
    `HRPC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, vld4_reg && !rdy5,
        vld4_reg && $stable(qr_reg) && $stable(qg_reg) && $stable(qb_reg),
        "stalled stage lost its beat")

endmodule

FILE: tb/hsv_to_rgb_pwm_compare_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for hsv_to_rgb_pwm_compare: directed and random colors
// under several full-scale settings, with random stalls on both streams
// depends on hrpc_pkg and the hsv_to_rgb_pwm_compare rtl
module hsv_to_rgb_pwm_compare_tb
    import hrpc_pkg::*;
();

    // arithmetic constants of the color conversion
    localparam int unsigned HUE_TURN    = 23040;
    localparam int unsigned SECTOR_SPAN = 3840;
    localparam int unsigned Q12_UNITY   = 4096;
    localparam int unsigned FRAC_BITS   = 36;
    // cycles allowed for the pipeline to settle, and the long output hold
    localparam int          PIPE_DRAIN  = 16;
    localparam int          HOLD_CYCLES = 80;
    // register index outside the map, writes to it must be ignored
    localparam logic [1:0]  REG_SPARE   = 2'd3;

    // one result beat, red in the low bits as on m_tdata
    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } compare_set_t;

    // predicts compare counts and checks result beats in order
    class pwm_compare_scoreboard;
        logic [15:0]  full_scale [3];
        compare_set_t expected_compares [$];
        int unsigned  colors_in;
        int unsigned  results_seen;
        int unsigned  errors;

        function new();
            full_scale[REG_RED_MAX]   = RED_MAX_RST;
            full_scale[REG_GREEN_MAX] = GREEN_MAX_RST;
            full_scale[REG_BLUE_MAX]  = BLUE_MAX_RST;
            colors_in    = 0;
            results_seen = 0;
            errors       = 0;
        endfunction

        function void set_full_scale(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_RED_MAX:   full_scale[REG_RED_MAX]   = val;
                REG_GREEN_MAX: full_scale[REG_GREEN_MAX] = val;
                REG_BLUE_MAX:  full_scale[REG_BLUE_MAX]  = val;
                default: ;
            endcase
        endfunction

        // channel is a numerator over 2^36 * 3840; floor of channel * max
        function logic [15:0] scale_channel(bit [63:0] chan, bit [15:0] full);
            bit [63:0] prod;
            prod = chan * full;
            return 16'((prod / SECTOR_SPAN) >> FRAC_BITS);
        endfunction

        function compare_set_t predict_compares(logic [15:0] hue, logic [12:0] sat_in,
                                                logic [12:0] val_in);
            bit [63:0]    hue_mod, sat, val, val_sq, chroma, offset;
            bit [63:0]    sector, frac, chroma_w, x_w, offset_w, red, green, blue;
            compare_set_t res;
            hue_mod = hue % HUE_TURN;
            // saturation and value clamp at 1.0
            sat     = (sat_in > Q12_UNITY) ? Q12_UNITY : sat_in;
            val     = (val_in > Q12_UNITY) ? Q12_UNITY : val_in;
            val_sq  = val * val;
            chroma  = val_sq * sat;
            offset  = val_sq * (Q12_UNITY - sat);
            sector  = hue_mod / SECTOR_SPAN;
            frac    = hue_mod % SECTOR_SPAN;
            chroma_w = chroma * SECTOR_SPAN;
            offset_w = offset * SECTOR_SPAN;
            // rising edge in even sectors, falling edge in odd ones
            x_w = sector[0] ? chroma * (SECTOR_SPAN - frac) : chroma * frac;
            red = 0;
            green = 0;
            blue = 0;
            case (sector)
                0: begin red = chroma_w; green = x_w; end
                1: begin red = x_w; green = chroma_w; end
                2: begin green = chroma_w; blue = x_w; end
                3: begin green = x_w; blue = chroma_w; end
                4: begin red = x_w; blue = chroma_w; end
                default: begin red = chroma_w; blue = x_w; end
            endcase
            res.red   = scale_channel(red + offset_w, full_scale[REG_RED_MAX]);
            res.green = scale_channel(green + offset_w, full_scale[REG_GREEN_MAX]);
            res.blue  = scale_channel(blue + offset_w, full_scale[REG_BLUE_MAX]);
            return res;
        endfunction

        function void note_color(logic [15:0] hue, logic [12:0] sat, logic [12:0] val);
            expected_compares.push_back(predict_compares(hue, sat, val));
            colors_in++;
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            compare_set_t got;
            compare_set_t want;
            got = data;
            results_seen++;
            if (expected_compares.size() == 0) begin
                $error("result beat with nothing expected: %h", data);
                errors++;
            end else begin
                want = expected_compares.pop_front();
                if (got.red !== want.red) begin
                    $error("red_compare mismatch: expected %0d, got %0d", want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green) begin
                    $error("green_compare mismatch: expected %0d, got %0d",
                           want.green, got.green);
                    errors++;
                end
                if (got.blue !== want.blue) begin
                    $error("blue_compare mismatch: expected %0d, got %0d",
                           want.blue, got.blue);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_compares.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;   // hue[15:0], saturation[28:16], brightness[41:29]
    logic              m_tvalid;
    logic              m_tready  = 1'b1;
    logic [OUT_W-1:0]  m_tdata;          // red_compare[15:0], green_compare[31:16],
                                         // blue_compare[47:32]
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_addr  = '0;
    logic [CMP_W-1:0]  cfg_wdata = '0;

    pwm_compare_scoreboard sb = new();

    bit          sender_gaps     = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit          hold_request    = 1'b0;
    int unsigned holds_done      = 0;
    int unsigned settings_used   = 1;

    hsv_to_rgb_pwm_compare u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("hsv_to_rgb_pwm_compare_tb: errors");
        $finish;
    end

    // result beats are checked on the edge that accepts them
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // output ready: random stall bursts, plus a long hold on request
    initial begin
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                holds_done++;
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // offer one color beat and hold it until accepted
    task automatic send_color(input logic [15:0] hue, input logic [12:0] sat,
                              input logic [12:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, sat, hue};
        do @(posedge aclk); while (!s_tready);
        sb.note_color(hue, sat, val);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // stop offering and let every expected beat come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    // write all three full-scale registers and one spare index, block idle
    task automatic program_full_scale(input logic [15:0] red, input logic [15:0] green,
                                      input logic [15:0] blue);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_RED_MAX;
        cfg_wdata <= red;
        @(posedge aclk);
        cfg_addr  <= REG_GREEN_MAX;
        cfg_wdata <= green;
        @(posedge aclk);
        cfg_addr  <= REG_BLUE_MAX;
        cfg_wdata <= blue;
        @(posedge aclk);
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= 16'($urandom_range(0, 65535));
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        sb.set_full_scale(REG_RED_MAX, red);
        sb.set_full_scale(REG_GREEN_MAX, green);
        sb.set_full_scale(REG_BLUE_MAX, blue);
        settings_used++;
    endtask

    // q12 field: mostly in range, with the ends and over-range values mixed in
    function automatic logic [12:0] pick_q12();
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return ONE_Q12;
            2:       return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (sender_gaps && $urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 15));
            send_color(16'($urandom_range(0, 65535)), pick_q12(), pick_q12());
        end
    endtask

    // stimulus
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed colors at the reset full-scale counts
        send_color(16'd0,     13'd0,    13'd4096);   // white
        send_color(16'd0,     13'd4096, 13'd4096);   // pure red
        send_color(16'd3839,  13'd4096, 13'd4096);   // end of first sector
        send_color(16'd3840,  13'd4096, 13'd4096);   // yellow
        send_color(16'd7679,  13'd4096, 13'd4096);
        send_color(16'd7680,  13'd4096, 13'd4096);   // green
        send_color(16'd11519, 13'd4096, 13'd4096);
        send_color(16'd11520, 13'd4096, 13'd4096);   // cyan
        send_color(16'd15359, 13'd4096, 13'd4096);
        send_color(16'd15360, 13'd4096, 13'd4096);   // blue
        send_color(16'd19199, 13'd4096, 13'd4096);
        send_color(16'd19200, 13'd4096, 13'd4096);   // magenta
        send_color(16'd23039, 13'd4096, 13'd4096);   // last hue before wrap
        send_color(16'd23040, 13'd4096, 13'd4096);   // wraps to red
        send_color(16'd46079, 13'd2048, 13'd4096);   // wraps once to 23039
        send_color(16'd65535, 13'd3000, 13'd4096);   // largest hue
        send_color(16'd1920,  13'd4097, 13'd4096);   // saturation just over 1.0
        send_color(16'd9000,  13'd8191, 13'd4096);   // saturation field all ones
        send_color(16'd17000, 13'd2048, 13'd4097);   // brightness just over 1.0
        send_color(16'd21000, 13'd1024, 13'd8191);   // brightness field all ones
        send_color(16'd5000,  13'd4096, 13'd0);      // black
        send_color(16'd5000,  13'd4096, 13'd1);      // dimmest step
        send_color(16'd1920,  13'd2048, 13'd2896);   // mid values
        wait_idle();

        // full scale at the top
        program_full_scale(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(300);
        wait_idle();

        // all channels off
        program_full_scale(16'h0000, 16'h0000, 16'h0000);
        run_random(150);
        wait_idle();

        // random counts, with a long output hold and a full drain mid-run
        program_full_scale(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
        run_random(100);
        hold_request = 1'b1;
        run_random(100);
        wait_idle();
        run_random(150);
        wait_idle();

        // mixed extremes
        program_full_scale(16'h0001, 16'hFFFF, 16'h8000);
        run_random(300);
        wait_idle();

        program_full_scale(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
        run_random(350);
        wait_idle();

        // last part at full rate on both sides
        program_full_scale(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        run_random(350);
        wait_idle();

        $display("run covered %0d colors and %0d compare beats over %0d full-scale settings",
                 sb.colors_in, sb.results_seen, settings_used);
        $display("output held off %0d time(s) for %0d cycles; %0d mismatches",
                 holds_done, HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("hsv_to_rgb_pwm_compare_tb: clean");
        else
            $display("hsv_to_rgb_pwm_compare_tb: errors");
        $finish;
    end

endmodule
